[rtl/core/lobm_pkg.sv]
// Package: shared types, codes and constants for the order book matcher.
package lobm_pkg;

  localparam int unsigned OrderCapacityDefault = 16;

  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_CANCEL = 3'd1,
    CMD_MODIFY = 3'd2,
    CMD_IOC    = 3'd3,
    CMD_MARKET = 3'd4
  } cmd_e;

  typedef enum logic [3:0] {
    EV_ACCEPTED      = 4'd0,
    EV_REJECTED      = 4'd1,
    EV_CANCELLED     = 4'd2,
    EV_CANCEL_FAILED = 4'd3,
    EV_MODIFIED      = 4'd4,
    EV_MODIFY_FAILED = 4'd5,
    EV_PARTIAL       = 4'd6,
    EV_FILLED        = 4'd7,
    EV_EXPIRED       = 4'd8
  } event_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_DECIDE,
    ST_SCAN,
    ST_CHECK,
    ST_FILL_IN,
    ST_FILL_REST,
    ST_REST,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [2:0]  command;
    logic        side;
    logic [31:0] order_ref;
    logic [15:0] trader_id;
    logic [23:0] quantity;
    logic [23:0] price;
    logic [31:0] event_time;
  } in_word_t;

  typedef struct packed {
    logic        result_side;
    logic [3:0]  event_code;
    logic [31:0] result_order_id;
    logic [15:0] result_owner_id;
    logic [23:0] result_quantity;
    logic [23:0] result_price;
    logic [31:0] result_time;
    logic        last_result;
  } out_word_t;

  // Result source selects for the datapath output mux.
  typedef enum logic [1:0] {
    SRC_INPUT,
    SRC_STORED,
    SRC_FILL_IN,
    SRC_FILL_REST
  } src_e;

  // Controller to datapath.
  typedef struct packed {
    logic     load;
    logic     scan_start;
    logic     scan_step;
    logic     id_scan;
    logic     trade;
    logic     remove_hit;
    logic     rest;
    logic     emit;
    logic     hold;
    logic     publish;
    src_e     src;
    event_e   code;
    logic     last;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic     scan_done;
    logic     hit;
    logic     hit_owner_ok;
    logic     hit_side_ok;
    logic     best_found;
    logic     price_ok;
    logic     qty_zero;
    logic     price_zero;
    logic     in_left_after;
    logic     rest_left_after;
    logic     free_found;
    logic     out_busy;
    cmd_e     command;
    logic     cmd_valid;
  } dp_status_t;

endpackage

[rtl/core/lobm_stream_if.sv]
// Interface: valid/ready channel carrying one word.
interface lobm_stream_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/limit_order_book_matcher_core.sv]
// Sequence: an input word first passes the id lookup (a full table scan) and
// the decision; a matching order then spends, per trade, a table scan, a check
// and two fill words, and ends with a final scan and rest or expiry. Output
// stalls hold back every step that emits a word.
// Throughput: one input at a time; the next is taken when the controller
// returns to idle. The sequential table scan sets the rate.
// Reset: asynchronous active low; empties the table and clears the sequence.
module limit_order_book_matcher_core import lobm_pkg::*; #(
  parameter int unsigned ORDER_CAPACITY = OrderCapacityDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  lobm_stream_if.sink   in_i,
  lobm_stream_if.source out_o
);
  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;
  in_word_t   in_word;

  // Input word arrives as a packed record.
  assign in_word = in_i.data;

  // Sequence the command: lookup, decide, then scan/trade/rest loop.
  lobm_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  // Hold the table, scan one entry a cycle, register each result word.
  lobm_datapath #(.OrderCapacity(ORDER_CAPACITY)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_word_o  (out_o.data)
  );
endmodule

[rtl/core/lobm_datapath.sv]
// Datapath: order table, sequential scan unit, fill arithmetic, output register.
module lobm_datapath import lobm_pkg::*; #(
  parameter int unsigned OrderCapacity = OrderCapacityDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  in_word_t    in_word_i,
  input  dp_cmd_t     cmd_i,
  output dp_status_t  status_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_word_t   out_word_o
);
  localparam int unsigned IdxW = (OrderCapacity > 1) ? $clog2(OrderCapacity) : 1;
  localparam int unsigned CntW = $clog2(OrderCapacity + 1);

  logic [OrderCapacity-1:0] valid_q;
  logic [31:0] oid_q   [OrderCapacity];
  logic [15:0] own_q   [OrderCapacity];
  logic        side_q  [OrderCapacity];
  logic [23:0] px_q    [OrderCapacity];
  logic [23:0] qty_q   [OrderCapacity];
  logic [31:0] seq_q   [OrderCapacity];
  logic [31:0] arrival_q;

  in_word_t    in_q;
  logic [23:0] rem_q;
  logic [CntW-1:0] idx_q;
  logic        hit_q, best_q, free_q;
  logic [IdxW-1:0] hit_idx_q, best_idx_q, free_idx_q;
  logic [23:0] fill_q;
  out_word_t   out_q;
  logic        out_valid_q;

  logic [IdxW-1:0] cur;
  logic        opp;
  logic        better;
  logic [23:0] bpx, bqty;

  assign cur  = idx_q[IdxW-1:0];
  assign opp  = ~in_q.side;
  assign bpx  = px_q[best_idx_q];
  assign bqty = qty_q[best_idx_q];

  always_comb begin
    better = 1'b0;
    if (valid_q[cur] && side_q[cur] == opp) begin
      if (!best_q) begin
        better = 1'b1;
      end else if (px_q[cur] != bpx) begin
        better = in_q.side ? (px_q[cur] > bpx) : (px_q[cur] < bpx);
      end else begin
        better = seq_q[cur] < seq_q[best_idx_q];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      arrival_q   <= '0;
      idx_q       <= '0;
      hit_q       <= 1'b0;
      best_q      <= 1'b0;
      free_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // A staged word stays invisible until the controller publishes it.
      if (cmd_i.publish || (cmd_i.emit && !cmd_i.hold)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load) begin
        in_q  <= in_word_i;
        rem_q <= in_word_i.quantity;
      end
      if (cmd_i.scan_start) begin
        idx_q  <= '0;
        best_q <= 1'b0;
        free_q <= 1'b0;
        if (cmd_i.id_scan) begin
          hit_q  <= 1'b0;
        end
      end
      if (cmd_i.scan_step) begin
        idx_q <= idx_q + 1'b1;
        if (cmd_i.id_scan) begin
          if (valid_q[cur] && oid_q[cur] == in_q.order_ref && !hit_q) begin
            hit_q     <= 1'b1;
            hit_idx_q <= cur;
          end
        end else if (better) begin
          best_q     <= 1'b1;
          best_idx_q <= cur;
        end
        if (!valid_q[cur] && !free_q) begin
          free_q     <= 1'b1;
          free_idx_q <= cur;
        end
      end
      if (cmd_i.trade) begin
        fill_q <= (rem_q < bqty) ? rem_q : bqty;
        rem_q  <= rem_q - ((rem_q < bqty) ? rem_q : bqty);
        qty_q[best_idx_q] <= bqty - ((rem_q < bqty) ? rem_q : bqty);
      end
      if (cmd_i.remove_hit) begin
        valid_q[hit_idx_q] <= 1'b0;
      end
      if (cmd_i.emit && cmd_i.src == SRC_FILL_REST && qty_q[best_idx_q] == '0) begin
        valid_q[best_idx_q] <= 1'b0;
      end
      if (cmd_i.rest) begin
        valid_q[free_idx_q] <= 1'b1;
        oid_q[free_idx_q]   <= in_q.order_ref;
        own_q[free_idx_q]   <= in_q.trader_id;
        side_q[free_idx_q]  <= in_q.side;
        px_q[free_idx_q]    <= in_q.price;
        qty_q[free_idx_q]   <= rem_q;
        seq_q[free_idx_q]   <= arrival_q;
        arrival_q           <= arrival_q + 32'd1;
      end
      if (cmd_i.publish) begin
        out_q.last_result <= cmd_i.last;
      end
      if (cmd_i.emit) begin
        out_q.result_time     <= in_q.event_time;
        out_q.event_code      <= cmd_i.code;
        out_q.last_result     <= cmd_i.last;
        unique case (cmd_i.src)
          SRC_INPUT: begin
            out_q.result_side     <= in_q.side;
            out_q.result_order_id <= in_q.order_ref;
            out_q.result_owner_id <= in_q.trader_id;
            out_q.result_quantity <= (cmd_i.code == EV_EXPIRED) ? rem_q : in_q.quantity;
            out_q.result_price    <= in_q.price;
          end
          SRC_STORED: begin
            out_q.result_side     <= side_q[hit_idx_q];
            out_q.result_order_id <= oid_q[hit_idx_q];
            out_q.result_owner_id <= own_q[hit_idx_q];
            out_q.result_quantity <= qty_q[hit_idx_q];
            out_q.result_price    <= px_q[hit_idx_q];
          end
          SRC_FILL_IN: begin
            out_q.result_side     <= in_q.side;
            out_q.result_order_id <= in_q.order_ref;
            out_q.result_owner_id <= in_q.trader_id;
            out_q.result_quantity <= fill_q;
            out_q.result_price    <= bpx;
          end
          default: begin
            out_q.result_side     <= opp;
            out_q.result_order_id <= oid_q[best_idx_q];
            out_q.result_owner_id <= own_q[best_idx_q];
            out_q.result_quantity <= fill_q;
            out_q.result_price    <= bpx;
          end
        endcase
      end
    end
  end

  always_comb begin
    status_o.scan_done       = (idx_q == CntW'(OrderCapacity - 1));
    status_o.hit             = hit_q;
    status_o.hit_owner_ok    = own_q[hit_idx_q] == in_q.trader_id;
    status_o.hit_side_ok     = side_q[hit_idx_q] == in_q.side;
    status_o.best_found      = best_q;
    status_o.price_ok        = (in_q.command == CMD_MARKET) ||
                               (in_q.side ? (bpx >= in_q.price) : (bpx <= in_q.price));
    status_o.qty_zero        = (rem_q == '0);
    status_o.price_zero      = (in_q.price == '0);
    status_o.in_left_after   = (rem_q != '0);
    status_o.rest_left_after = (bqty != '0);
    status_o.free_found      = free_q;
    status_o.out_busy        = out_valid_q && !out_ready_i;
    status_o.cmd_valid       = in_q.command <= CMD_MARKET;
    status_o.command         = cmd_e'(in_q.command);
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
endmodule

[rtl/core/lobm_controller.sv]
// Controller: command sequencing state machine.
module lobm_controller import lobm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.src  = SRC_INPUT;
    cmd_o.code = EV_ACCEPTED;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load       = 1'b1;
          cmd_o.scan_start = 1'b1;
          cmd_o.id_scan    = 1'b1;
          state_d          = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd_o.scan_step = 1'b1;
        cmd_o.id_scan   = 1'b1;
        if (status_i.scan_done) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        // Every valid command emits one word here, so hold for a free output.
        if (!status_i.cmd_valid) begin
          state_d = ST_IDLE;
        end else if (!status_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
          cmd_o.last = 1'b1;
          unique case (status_i.command)
            CMD_ADD: begin
              if (status_i.hit) begin
                cmd_o.code = EV_REJECTED;
              end else if (!status_i.qty_zero) begin
                // Stage the accept word; its last flag waits for the scan.
                cmd_o.hold       = 1'b1;
                cmd_o.scan_start = 1'b1;
                state_d          = ST_SCAN;
              end
            end
            CMD_CANCEL: begin
              if (status_i.hit && status_i.hit_owner_ok) begin
                cmd_o.code       = EV_CANCELLED;
                cmd_o.src        = SRC_STORED;
                cmd_o.remove_hit = 1'b1;
              end else begin
                cmd_o.code = EV_CANCEL_FAILED;
              end
            end
            CMD_MODIFY: begin
              if (status_i.qty_zero || status_i.price_zero || !status_i.hit ||
                  !status_i.hit_owner_ok || !status_i.hit_side_ok) begin
                cmd_o.code = EV_MODIFY_FAILED;
              end else begin
                cmd_o.code       = EV_MODIFIED;
                cmd_o.remove_hit = 1'b1;
                cmd_o.hold       = 1'b1;
                cmd_o.scan_start = 1'b1;
                state_d          = ST_SCAN;
              end
            end
            default: begin
              if (status_i.qty_zero || status_i.hit ||
                  (status_i.command == CMD_IOC && status_i.price_zero)) begin
                cmd_o.code = EV_REJECTED;
              end else begin
                cmd_o.hold       = 1'b1;
                cmd_o.scan_start = 1'b1;
                state_d          = ST_SCAN;
              end
            end
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_done) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        // A trade follows, so the staged word is not the last one.
        if (!status_i.qty_zero && status_i.best_found && status_i.price_ok) begin
          cmd_o.publish = 1'b1;
          cmd_o.trade   = 1'b1;
          state_d       = ST_FILL_IN;
        end else begin
          state_d = ST_REST;
        end
      end
      ST_FILL_IN: begin
        if (!status_i.out_busy) begin
          cmd_o.emit = 1'b1;
          cmd_o.src  = SRC_FILL_IN;
          cmd_o.code = status_i.in_left_after ? EV_PARTIAL : EV_FILLED;
          state_d    = ST_FILL_REST;
        end
      end
      ST_FILL_REST: begin
        if (!status_i.out_busy) begin
          cmd_o.emit = 1'b1;
          cmd_o.src  = SRC_FILL_REST;
          cmd_o.code = status_i.rest_left_after ? EV_PARTIAL : EV_FILLED;
          if (status_i.in_left_after) begin
            // Stage the word until the next scan shows whether more follows.
            cmd_o.hold       = 1'b1;
            cmd_o.scan_start = 1'b1;
            state_d          = ST_SCAN;
          end else begin
            cmd_o.last = 1'b1;
            state_d    = ST_IDLE;
          end
        end
      end
      ST_REST: begin
        // Publish the staged word; it is last unless an expiry follows.
        cmd_o.publish = 1'b1;
        cmd_o.last    = 1'b1;
        if (status_i.qty_zero) begin
          state_d = ST_IDLE;
        end else if ((status_i.command == CMD_ADD || status_i.command == CMD_MODIFY) &&
                     status_i.free_found) begin
          cmd_o.rest = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          cmd_o.last = 1'b0;
          state_d    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!status_i.out_busy) begin
          cmd_o.emit = 1'b1;
          cmd_o.code = EV_EXPIRED;
          cmd_o.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

[rtl/core/lobm_checker.sv]
// Checker: port-level assertions, bound to the top level.
module lobm_checker import lobm_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data.event_code <= EV_EXPIRED)
    else $error("event code out of range");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");
  a_fill_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_data.event_code == EV_FILLED ||
                  out_data.event_code == EV_PARTIAL) |-> out_data.result_quantity != '0)
    else $error("zero fill");
endmodule

bind limit_order_book_matcher_core lobm_checker u_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_data  (out_o.data)
);

[sim/limit_order_book_matcher_checker.sv]
// Checker: order book predictor and result comparison for the matcher core.
`timescale 1ns / 100ps

module limit_order_book_matcher_checker import lobm_pkg::*; #(
  parameter int unsigned ORDER_CAPACITY = OrderCapacityDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_word_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_word_t out_data_i,
  output int        fail_count_o,
  output int        pending_o
);

  logic        book_valid [ORDER_CAPACITY];
  logic [31:0] book_id    [ORDER_CAPACITY];
  logic [15:0] book_owner [ORDER_CAPACITY];
  logic        book_side  [ORDER_CAPACITY];
  logic [23:0] book_price [ORDER_CAPACITY];
  logic [23:0] book_qty   [ORDER_CAPACITY];
  logic [31:0] book_seq   [ORDER_CAPACITY];
  logic [31:0] arrivals;

  out_word_t expected_results [$];
  out_word_t step_results [$];
  int        fail_count;
  int        pending_count;

  assign fail_count_o = fail_count;
  assign pending_o    = pending_count;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  function automatic int find_order(input logic [31:0] id);
    for (int k = 0; k < ORDER_CAPACITY; k++)
      if (book_valid[k] && book_id[k] == id) return k;
    return -1;
  endfunction

  // Buys: highest price wins; sells: lowest; ties go to the oldest sequence.
  function automatic int best_resting(input logic s);
    int b;
    b = -1;
    for (int k = 0; k < ORDER_CAPACITY; k++) begin
      if (!book_valid[k] || book_side[k] != s) continue;
      if (b < 0) b = k;
      else if (book_price[k] != book_price[b]) begin
        if (s == 1'b0 ? book_price[k] > book_price[b] : book_price[k] < book_price[b])
          b = k;
      end else if (book_seq[k] < book_seq[b]) b = k;
    end
    return b;
  endfunction

  task automatic add_result(input logic side, input event_e code, input logic [31:0] id,
                            input logic [15:0] owner, input logic [23:0] qty,
                            input logic [23:0] px, input logic [31:0] tm);
    out_word_t r;
    r = '{side, code, id, owner, qty, px, tm, 1'b0};
    step_results = {step_results, r};
  endtask

  task automatic cross_book(input in_word_t w, inout logic [23:0] qty, input logic use_limit);
    int k;
    logic [23:0] px, d;
    while (qty > 0) begin
      k = best_resting(~w.side);
      if (k < 0) break;
      px = book_price[k];
      if (use_limit && (w.side == 1'b0 ? px > w.price : px < w.price)) break;
      d = (qty < book_qty[k]) ? qty : book_qty[k];
      qty -= d;
      book_qty[k] -= d;
      add_result(w.side, qty > 0 ? EV_PARTIAL : EV_FILLED, w.order_ref, w.trader_id,
                 d, px, w.event_time);
      add_result(~w.side, book_qty[k] > 0 ? EV_PARTIAL : EV_FILLED, book_id[k],
                 book_owner[k], d, px, w.event_time);
      if (book_qty[k] == 0) book_valid[k] = 1'b0;
    end
  endtask

  function automatic logic place_order(input in_word_t w, input logic [23:0] qty);
    for (int k = 0; k < ORDER_CAPACITY; k++)
      if (!book_valid[k]) begin
        book_valid[k] = 1'b1;
        book_id[k]    = w.order_ref;
        book_owner[k] = w.trader_id;
        book_side[k]  = w.side;
        book_price[k] = w.price;
        book_qty[k]   = qty;
        book_seq[k]   = arrivals;
        arrivals      = arrivals + 32'd1;
        return 1'b1;
      end
    return 1'b0;
  endfunction

  task automatic predict_book(input in_word_t w);
    int k;
    logic [23:0] qty;
    qty = w.quantity;
    step_results.delete();
    case (w.command)
      CMD_ADD, CMD_MODIFY: begin
        if (w.command == CMD_ADD) begin
          if (find_order(w.order_ref) >= 0) begin
            add_result(w.side, EV_REJECTED, w.order_ref, w.trader_id, qty, w.price,
                       w.event_time);
            k = -2;
          end else begin
            add_result(w.side, EV_ACCEPTED, w.order_ref, w.trader_id, qty, w.price,
                       w.event_time);
            k = 0;
          end
        end else begin
          k = (qty == 0 || w.price == 0) ? -1 : find_order(w.order_ref);
          if (k < 0 || book_owner[k] != w.trader_id || book_side[k] != w.side) begin
            add_result(w.side, EV_MODIFY_FAILED, w.order_ref, w.trader_id, qty, w.price,
                       w.event_time);
            k = -2;
          end else begin
            book_valid[k] = 1'b0;
            add_result(w.side, EV_MODIFIED, w.order_ref, w.trader_id, qty, w.price,
                       w.event_time);
          end
        end
        if (k != -2) begin
          cross_book(w, qty, 1'b1);
          if (qty > 0 && !place_order(w, qty))
            add_result(w.side, EV_EXPIRED, w.order_ref, w.trader_id, qty, w.price,
                       w.event_time);
        end
      end
      CMD_CANCEL: begin
        k = find_order(w.order_ref);
        if (k < 0 || book_owner[k] != w.trader_id)
          add_result(w.side, EV_CANCEL_FAILED, w.order_ref, w.trader_id, qty, w.price,
                     w.event_time);
        else begin
          add_result(book_side[k], EV_CANCELLED, book_id[k], book_owner[k], book_qty[k],
                     book_price[k], w.event_time);
          book_valid[k] = 1'b0;
        end
      end
      CMD_IOC, CMD_MARKET: begin
        if (qty == 0 || (w.command == CMD_IOC && w.price == 0) ||
            find_order(w.order_ref) >= 0)
          add_result(w.side, EV_REJECTED, w.order_ref, w.trader_id, qty, w.price,
                     w.event_time);
        else begin
          add_result(w.side, EV_ACCEPTED, w.order_ref, w.trader_id, qty, w.price,
                     w.event_time);
          cross_book(w, qty, w.command == CMD_IOC);
          if (qty > 0)
            add_result(w.side, EV_EXPIRED, w.order_ref, w.trader_id, qty, w.price,
                       w.event_time);
        end
      end
      default: ; // unknown codes leave the book alone
    endcase
    foreach (step_results[i]) begin
      if (i == step_results.size() - 1) step_results[i].last_result = 1'b1;
      expected_results = {expected_results, step_results[i]};
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      for (int k = 0; k < ORDER_CAPACITY; k++) book_valid[k] = 1'b0;
      arrivals = '0;
      expected_results.delete();
      pending_count = 0;
    end else begin
      // Retire the result first: it belongs to an earlier input word.
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0)
          report_mismatch("result word with nothing expected");
        else begin
          want = expected_results.pop_front();
          check_field("result_side", out_data_i.result_side, want.result_side);
          check_field("event_code", out_data_i.event_code, want.event_code);
          check_field("result_order_id", out_data_i.result_order_id, want.result_order_id);
          check_field("result_owner_id", out_data_i.result_owner_id, want.result_owner_id);
          check_field("result_quantity", out_data_i.result_quantity, want.result_quantity);
          check_field("result_price", out_data_i.result_price, want.result_price);
          check_field("result_time", out_data_i.result_time, want.result_time);
          check_field("last_result", out_data_i.last_result, want.last_result);
        end
      end
      if (in_valid_i && in_ready_i) predict_book(in_data_i);
      pending_count = expected_results.size();
    end
  end

  initial fail_count = 0;

endmodule

[sim/limit_order_book_matcher_core_tb.sv]
// Testbench top: stimulus, handshake pressure and verdict for the matcher core.
`timescale 1ns / 100ps

module limit_order_book_matcher_core_tb;
  import lobm_pkg::*;

  localparam int CycleLimit   = 600000;
  localparam int DrainCycles  = 500;   // worst item: full-book sweep of 34 results
  localparam int HoldOffCycles = 400;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   cycles;
  logic idle_on;
  logic hold_req;
  int   hold_left;

  lobm_stream_if #(.word_t(in_word_t))  in_ch ();
  lobm_stream_if #(.word_t(out_word_t)) out_ch ();

  limit_order_book_matcher_core DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  limit_order_book_matcher_checker book_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_i  (in_ch.ready),
    .in_data_i   (in_ch.data),
    .out_valid_i (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .out_data_i  (out_ch.data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // 12 ns period.
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog: cap the run at a generous cycle count.
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off counted here on request.
  initial hold_left = 0;
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldOffCycles;
      hold_req  <= 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !(idle_on && $urandom_range(99) < 9);
    end
  end

  // Offer one word from a falling edge; return at the falling edge after acceptance.
  task automatic send_word(input in_word_t w);
    while (idle_on && $urandom_range(99) < 9) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    forever begin
      @(posedge clk_i);
      if (in_ch.ready) break;
    end
    @(negedge clk_i);
  endtask

  function automatic in_word_t make_word(input cmd_e cmd, input logic side,
                                         input logic [31:0] id, input logic [15:0] owner,
                                         input logic [23:0] qty, input logic [23:0] px);
    in_word_t w;
    w = '{cmd, side, id, owner, qty, px, $urandom};
    return w;
  endfunction

  // Mostly well-formed orders on a small id pool and a narrow price band, so
  // that orders cross, rest, collide and get cancelled; the rest is noise.
  function automatic in_word_t random_word();
    in_word_t w;
    int r;
    r = $urandom_range(99);
    w.command    = cmd_e'(r < 40 ? CMD_ADD : r < 55 ? CMD_CANCEL : r < 70 ? CMD_MODIFY :
                          r < 83 ? CMD_IOC : r < 95 ? CMD_MARKET : $urandom_range(7));
    w.side       = 1'($urandom_range(1));
    w.event_time = $urandom;
    if ($urandom_range(99) < 85) begin
      w.order_ref = $urandom_range(30, 1);
      w.trader_id = 16'($urandom_range(3, 1));
      w.quantity  = ($urandom_range(99) < 4) ? 24'd0 : 24'($urandom_range(40, 1));
      w.price     = ($urandom_range(99) < 4) ? 24'd0 : 24'($urandom_range(106, 94));
    end else begin
      w.order_ref = $urandom;
      w.trader_id = 16'($urandom);
      w.quantity  = 24'($urandom);
      w.price     = 24'($urandom);
    end
    return w;
  endfunction

  initial begin
    in_word_t w;
    int n;
    rst_ni       = 1'b0;
    idle_on      = 1'b1;
    hold_req     = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Fill the book with sixteen bids at rising prices.
    for (int i = 1; i <= 16; i++)
      send_word(make_word(CMD_ADD, 1'b0, 32'(i), 16'd7, 24'd10, 24'(100 + i)));
    // Book full: the remainder expires.
    send_word(make_word(CMD_ADD, 1'b0, 32'd17, 16'd7, 24'd10, 24'd50));
    // Duplicate id.
    send_word(make_word(CMD_ADD, 1'b0, 32'd3, 16'd7, 24'd5, 24'd90));
    // Cancel with the wrong owner, then the right one.
    send_word(make_word(CMD_CANCEL, 1'b0, 32'd5, 16'd8, 24'd0, 24'd0));
    send_word(make_word(CMD_CANCEL, 1'b0, 32'd5, 16'd7, 24'd0, 24'd0));
    // Modify: success loses time priority; wrong side fails.
    send_word(make_word(CMD_MODIFY, 1'b0, 32'd6, 16'd7, 24'd20, 24'd200));
    send_word(make_word(CMD_MODIFY, 1'b1, 32'd7, 16'd7, 24'd20, 24'd200));
    // IOC with zero quantity is rejected.
    send_word(make_word(CMD_IOC, 1'b1, 32'd100, 16'd9, 24'd0, 24'd100));
    // Market sell with the largest quantity sweeps the whole bid side.
    send_word(make_word(CMD_MARKET, 1'b1, 32'd101, 16'd9, 24'hFFFFFF, 24'd0));
    // Market with zero quantity, an unknown code, and an empty add at the extremes.
    send_word(make_word(CMD_MARKET, 1'b0, 32'd102, 16'd9, 24'd0, 24'd5));
    w = make_word(CMD_ADD, 1'b0, 32'd0, 16'd0, 24'd0, 24'd0);
    w.command = cmd_e'(3'd5);
    send_word(w);
    w = make_word(CMD_ADD, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 24'd0, 24'hFFFFFF);
    w.event_time = 32'hFFFF_FFFF;
    send_word(w);

    n = 0;
    while (n < 220) begin
      if (n == 60) hold_req <= 1'b1;          // starve the result side for a while
      idle_on <= !(n >= 100 && n < 160);      // stretch with no idling on either side
      if (n == 180) begin
        // Pause the feed until the book has answered everything so far.
        in_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (DrainCycles) @(negedge clk_i);
      end
      w = random_word();
      send_word(w);
      if (w.command <= CMD_MARKET) n++;
    end
    in_ch.valid <= 1'b0;

    wait (pending == 0);
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
